// ===== rtl/ovns_pkg.sv =====
// Shared types and constants for the octave value noise sampler.
// No dependencies; imported by every module of the block.
`default_nettype none
package ovns_pkg;

  localparam int COORD_W = 5;
  localparam int NOISE_W = 16;
  localparam int OCT_W   = 3;
  localparam int PERS_W  = 16;
  localparam int AMP_W   = 29;
  localparam int TOTAL_W = 32;
  localparam int SAMP_W  = 13;
  localparam int SUM_W   = 46;
  localparam int NUM_W   = SUM_W + 4;

  localparam logic       MODE_WRITE = 1'b0;
  localparam logic       MODE_QUERY = 1'b1;

  localparam logic       CFG_IDX_OCTAVE_COUNT = 1'b0;
  localparam logic       CFG_IDX_PERSISTENCE  = 1'b1;

  localparam logic [OCT_W-1:0]  OCTAVE_COUNT_RST = 3'd2;
  localparam logic [PERS_W-1:0] PERSISTENCE_RST  = 16'd16384;
  localparam logic [AMP_W-1:0]  AMP_ONE          = 29'd16384;

  typedef struct packed {
    logic               is_query;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               cell_bit;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/octave_value_noise_sampler_top.sv =====
// Top level of the octave value noise sampler: config registers, front
// queue and back engine. Uses ovns_pkg, ovns_front, ovns_back.
//
//  channel  handshake            payload
//  in_      in_push / in_full    in_mode, in_col, in_row, in_cell_bit
//  out_     out_pop / out_empty  out_noise_value, out_col, out_row
//  cfg_     cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A cell write is done by the back end on dispatch. A query takes, per
// octave, four corner reads from the grid memory, amplitude update,
// blend, weight multiply and accumulate, after dispatch; then divider
// start, the bit-serial divider and result load, for up to 7 octaves.
// A zero total weight gives a zero result with no divider steps; a
// saturating quotient skips the 16 divider steps.
// Reset is synchronous; the grid memory is not cleared.
// A full result slot stalls the back end; the front queue keeps accepting
// until its two entries fill.
`default_nettype none
module octave_value_noise_sampler_top
  import ovns_pkg::*;
#(
  parameter int GRID_LOG2 = 5
)(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output      logic               in_full,
  input  wire logic               in_mode,
  input  wire logic [COORD_W-1:0] in_col,
  input  wire logic [COORD_W-1:0] in_row,
  input  wire logic               in_cell_bit,
  output      logic               out_empty,
  input  wire logic               out_pop,
  output      logic [NOISE_W-1:0] out_noise_value,
  output      logic [COORD_W-1:0] out_col,
  output      logic [COORD_W-1:0] out_row,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [PERS_W-1:0]  cfg_data
);

  logic [OCT_W-1:0]  octave_count_r;
  logic [PERS_W-1:0] persistence_r;
  logic              cmd_valid, cmd_pop;
  cmd_t              cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= OCTAVE_COUNT_RST;
      persistence_r  <= PERSISTENCE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_OCTAVE_COUNT: octave_count_r <= cfg_data[OCT_W-1:0];
        CFG_IDX_PERSISTENCE:  persistence_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  ovns_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_mode     (in_mode),
    .in_col      (in_col),
    .in_row      (in_row),
    .in_cell_bit (in_cell_bit),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  ovns_back #(.GRID_LOG2(GRID_LOG2)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .octave_count    (octave_count_r),
    .persistence     (persistence_r),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_noise_value (out_noise_value),
    .out_col         (out_col),
    .out_row         (out_row)
  );

endmodule
`default_nettype wire

// ===== rtl/ovns_front.sv =====
// Front end: accepts input requests, tags them as cell writes or queries
// and holds them in a two-entry queue for the back end. Uses ovns_pkg.
`default_nettype none
module ovns_front
  import ovns_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output      logic               in_full,
  input  wire logic               in_mode,
  input  wire logic [COORD_W-1:0] in_col,
  input  wire logic [COORD_W-1:0] in_row,
  input  wire logic               in_cell_bit,
  output      logic               cmd_valid,
  output      cmd_t               cmd,
  input  wire logic               cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;
  cmd_t       new_cmd;

  assign in_full   = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    new_cmd.is_query = (in_mode == MODE_QUERY);
    new_cmd.col      = in_col;
    new_cmd.row      = in_row;
    new_cmd.cell_bit = in_cell_bit;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= 2'(count_r + {1'b0, do_push} - {1'b0, do_pop});
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ovns_div.sv =====
// Normalizing divider: restoring division, one quotient bit per cycle,
// with zero-divisor and saturation handled at start. Uses ovns_pkg.
`default_nettype none
module ovns_div
  import ovns_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [TOTAL_W-1:0] den,
  output      logic               done,
  output      logic [NOISE_W-1:0] quo
);

  logic               busy_r, done_r;
  logic [4:0]         cnt_r;
  logic [TOTAL_W-1:0] rem_r, den_r;
  logic [NOISE_W-1:0] quo_r, nlo_r;
  logic [TOTAL_W:0]   trial;
  logic               fits;

  assign done  = done_r;
  assign quo   = quo_r;
  assign trial = {rem_r, nlo_r[NOISE_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (start) begin
      if (den == '0) begin
        quo_r  <= '0;
        done_r <= 1'b1;
        busy_r <= 1'b0;
      end else if (num >= {2'b00, den, 16'h0000}) begin
        quo_r  <= '1;
        done_r <= 1'b1;
        busy_r <= 1'b0;
      end else begin
        // upper bits are zero here since num < den * 2^16
        rem_r  <= num[NOISE_W+TOTAL_W-1:NOISE_W];
        nlo_r  <= num[NOISE_W-1:0];
        den_r  <= den;
        quo_r  <= '0;
        cnt_r  <= 5'd16;
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end
    end else if (busy_r) begin
      rem_r <= fits ? TOTAL_W'(trial - {1'b0, den_r}) : trial[TOTAL_W-1:0];
      quo_r <= {quo_r[NOISE_W-2:0], fits};
      nlo_r <= {nlo_r[NOISE_W-2:0], 1'b0};
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ovns_back.sv =====
// Back end: grid memory, per-octave corner reads, weighting and sum,
// then the divider and a one-entry result slot. Uses ovns_pkg, ovns_div.
`default_nettype none
module ovns_back
  import ovns_pkg::*;
#(
  parameter int GRID_LOG2 = 5
)(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  input  wire cmd_t               cmd,
  output      logic               cmd_pop,
  input  wire logic [OCT_W-1:0]   octave_count,
  input  wire logic [PERS_W-1:0]  persistence,
  output      logic               out_empty,
  input  wire logic               out_pop,
  output      logic [NOISE_W-1:0] out_noise_value,
  output      logic [COORD_W-1:0] out_col,
  output      logic [COORD_W-1:0] out_row
);

  localparam int G      = GRID_LOG2;
  localparam int ADDR_W = 2 * G;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int EW     = G + 7;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SMP  = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;

  logic              mem [DEPTH];
  logic              rd_r;
  logic [ADDR_W-1:0] raddr, waddr;
  logic              we;

  logic [2:0]           state_r;
  logic [2:0]           cnt_r;
  logic [OCT_W-1:0]     i_r, k;
  logic [G-1:0]         c_r, r_r;
  logic [COORD_W-1:0]   col_r, row_r;
  logic [3:0]           corners_r;
  logic [AMP_W-1:0]     amp_r;
  logic [AMP_W+PERS_W-1:0] prod_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SAMP_W-1:0]    samp_r;
  logic [SAMP_W+AMP_W-1:0] wprod_r;
  logic [AMP_W-1:0]     amp_nxt;

  logic                 ovalid_r;
  logic [NOISE_W-1:0]   onoise_r;
  logic [COORD_W-1:0]   ocol_r, orow_r;

  logic [EW-1:0] ce, re, pe, pm1, nmask, c0e, c1e, r0e, r1e;
  logic [6:0]    hf, vf, p7;
  logic [7:0]    top, bot;
  logic [15:0]   v16;
  logic [3:0]    shamt;
  logic [SAMP_W-1:0] samp_nxt;
  logic [EW-1:0] cs, rs;

  logic               div_start, div_done;
  logic [NOISE_W-1:0] div_quo;

  // octave geometry for the current k
  always_comb begin
    k     = i_r - 3'd1;
    ce    = EW'(c_r);
    re    = EW'(r_r);
    pe    = EW'(1) << k;
    pm1   = pe - EW'(1);
    nmask = (EW'(1) << G) - EW'(1);
    c0e   = ce & ~pm1 & nmask;
    r0e   = re & ~pm1 & nmask;
    c1e   = (c0e + pe) & nmask;
    r1e   = (r0e + pe) & nmask;
    hf    = 7'(ce - c0e);
    vf    = 7'(re - r0e);
    p7    = 7'(pe);
    top   = (corners_r[0] ? {1'b0, 7'(p7 - hf)} : 8'd0) + (corners_r[1] ? {1'b0, hf} : 8'd0);
    bot   = (corners_r[2] ? {1'b0, 7'(p7 - hf)} : 8'd0) + (corners_r[3] ? {1'b0, hf} : 8'd0);
    v16   = 16'(16'(top) * 16'(7'(p7 - vf)) + 16'(bot) * 16'(vf));
    shamt = 4'd12 - {k, 1'b0};
    samp_nxt = SAMP_W'(v16 << shamt);
    cs    = cnt_r[0] ? c1e : c0e;
    rs    = cnt_r[1] ? r1e : r0e;
    raddr = {cs[G-1:0], rs[G-1:0]};
    waddr = {G'(cmd.col), G'(cmd.row)};
    amp_nxt = AMP_W'((prod_r + (AMP_W+PERS_W)'(8192)) >> 14);
  end

  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign we        = cmd_pop && !cmd.is_query;
  assign div_start = (state_r == S_DIV);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= cmd.cell_bit;
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      cnt_r    <= 3'd0;
      i_r      <= '0;
    end else begin
      if (out_pop && ovalid_r) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid && cmd.is_query) begin
            c_r     <= G'(cmd.col);
            r_r     <= G'(cmd.row);
            col_r   <= cmd.col;
            row_r   <= cmd.row;
            amp_r   <= AMP_ONE;
            total_r <= '0;
            sum_r   <= '0;
            i_r     <= octave_count;
            cnt_r   <= 3'd0;
            state_r <= (octave_count == '0) ? S_DIV : S_RD;
          end
        end
        S_RD: begin
          if (cnt_r == 3'd0) prod_r <= amp_r * persistence;
          if (cnt_r == 3'd1) begin
            amp_r   <= amp_nxt;
            total_r <= total_r + TOTAL_W'(amp_nxt);
          end
          if (cnt_r != 3'd0) corners_r[2'(cnt_r - 3'd1)] <= rd_r;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) state_r <= S_SMP;
        end
        S_SMP: begin
          samp_r  <= samp_nxt;
          state_r <= S_MAC;
        end
        S_MAC: begin
          wprod_r <= samp_r * amp_r;
          state_r <= S_ADD;
        end
        S_ADD: begin
          sum_r <= sum_r + SUM_W'(wprod_r);
          i_r   <= i_r - 3'd1;
          cnt_r <= 3'd0;
          state_r <= (i_r == 3'd1) ? S_DIV : S_RD;
        end
        S_DIV: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          // hold the result until the output slot drains
          if (div_done && !ovalid_r) begin
            ovalid_r <= 1'b1;
            onoise_r <= div_quo;
            ocol_r   <= col_r;
            orow_r   <= row_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ovns_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({sum_r, 4'b0000}),
    .den   (total_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_empty       = !ovalid_r;
  assign out_noise_value = onoise_r;
  assign out_col         = ocol_r;
  assign out_row         = orow_r;

endmodule
`default_nettype wire
